### hdl/mfps_pkg.sv
// Shared types and constants for the minimum falling path sum block.
package mfps_pkg;

    // Largest matrix side the cost row can hold.
    localparam int MAX_SIZE = 128;

    // Width of a column or row index, and of a size value 1..MAX_SIZE.
    localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int N_W   = $clog2(MAX_SIZE + 1);

    // Field widths.
    localparam int CFG_W   = 8;
    localparam int ENTRY_W = 16;
    localparam int COST_W  = 23;
    localparam int OUT_W   = 24;

    // Saturation limits of a path cost.
    localparam logic signed [COST_W-1:0] COST_MAX = {1'b0, {(COST_W-1){1'b1}}};
    localparam logic signed [COST_W-1:0] COST_MIN = {1'b1, {(COST_W-1){1'b0}}};

    typedef logic signed [COST_W-1:0] t_cost;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [N_W-1:0]           t_size;

endpackage

### hdl/mfps_ram.sv
// Simple dual-port RAM with a registered read port, holding the cost row.
module mfps_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 23
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/min_falling_path_sum.sv
// Top level of the streaming minimum falling path sum block.
//
//  Channel   Direction  Signals                         Contents
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tdata[15:0] entry_value
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata[23:0] min_path_sum
//  cfg       in         i_cfg_we, i_cfg_data[7:0]        matrix_size
//
// One matrix entry is taken per clock cycle, but for the stall below. The
// cost row lives in one RAM: each entry writes its own column and reads the
// column two ahead; the above/right window registers hide the read delay.
// The result is registered and valid in the cycle after the last entry.
// Entries keep flowing while a result waits; only the last entry of the
// next matrix stalls while the previous result has not been taken.
// Reset is synchronous, active low, and needs no clearing pass.
module min_falling_path_sum (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write.
    input  logic                          i_cfg_we,
    input  logic [mfps_pkg::CFG_W-1:0]    i_cfg_data,      // [7:0] matrix_size
    // Entry stream.
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [mfps_pkg::ENTRY_W-1:0]  i_s_axis_tdata,  // [15:0] entry_value
    // Result stream.
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [mfps_pkg::OUT_W-1:0]    o_m_axis_tdata   // [23:0] min_path_sum
);

    // Control state.
    mfps_pkg::t_size r_n;
    mfps_pkg::t_idx  r_col;
    mfps_pkg::t_idx  r_row;
    mfps_pkg::t_cost r_min;
    logic            r_pend;
    logic            r_out_valid;

    // Window and payload registers.
    mfps_pkg::t_cost r_above;
    mfps_pkg::t_cost r_right;
    mfps_pkg::t_cost r_left;
    mfps_pkg::t_cost r_col0;
    mfps_pkg::t_cost r_col1;
    logic signed [mfps_pkg::OUT_W-1:0] r_out;

    logic            in_acc;
    logic            out_acc;
    logic            last_col;
    logic            last_row;
    logic            is_last;
    mfps_pkg::t_cost rd_data;
    mfps_pkg::t_cost right_cur;
    mfps_pkg::t_cost best;
    mfps_pkg::t_cost cost;
    mfps_pkg::t_cost new_min;
    logic signed [mfps_pkg::OUT_W-1:0] sum;
    logic signed [mfps_pkg::ENTRY_W-1:0] entry;

    // Position within the matrix.
    assign last_col = (mfps_pkg::N_W'(r_col) + mfps_pkg::N_W'(1)) == r_n;
    assign last_row = (mfps_pkg::N_W'(r_row) + mfps_pkg::N_W'(1)) == r_n;
    assign is_last  = last_col && last_row;

    // Handshakes: only a result-producing entry waits for the output register.
    assign o_s_axis_tready = !(r_out_valid && !i_m_axis_tready && is_last);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc         = r_out_valid && i_m_axis_tready;

    // The right neighbor comes straight from the RAM when its read just landed.
    assign right_cur = r_pend ? rd_data : r_right;

    // Least of the three neighbors of the previous row, then the new cost.
    always_comb begin
        best = r_above;
        if ((r_col != '0) && (r_left < best)) begin
            best = r_left;
        end
        if (!last_col && (right_cur < best)) begin
            best = right_cur;
        end
    end

    assign entry = $signed(i_s_axis_tdata);
    assign sum   = mfps_pkg::OUT_W'(entry) + mfps_pkg::OUT_W'(best);

    always_comb begin
        if (r_row == '0) begin
            cost = mfps_pkg::COST_W'(entry);
        end else if (sum > mfps_pkg::OUT_W'(mfps_pkg::COST_MAX)) begin
            cost = mfps_pkg::COST_MAX;
        end else if (sum < mfps_pkg::OUT_W'(mfps_pkg::COST_MIN)) begin
            cost = mfps_pkg::COST_MIN;
        end else begin
            cost = mfps_pkg::COST_W'(sum);
        end
    end

    assign new_min = (last_row && (cost < r_min)) ? cost : r_min;

    // Cost row: write this column, fetch the one two places ahead.
    mfps_ram #(
        .DEPTH (mfps_pkg::MAX_SIZE),
        .WIDTH (mfps_pkg::COST_W)
    ) u_row (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_col),
        .i_wdata (cost),
        .i_re    (in_acc && !last_col),
        .i_raddr (r_col + mfps_pkg::IDX_W'(2)),
        .o_rdata (rd_data)
    );

    // Matrix position, running minimum and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n   <= mfps_pkg::N_W'(1);
            r_col <= '0;
            r_row <= '0;
            r_min <= mfps_pkg::COST_MAX;
        end else if (i_cfg_we) begin
            if (i_cfg_data == '0) begin
                r_n <= mfps_pkg::N_W'(1);
            end else if (int'(i_cfg_data) > mfps_pkg::MAX_SIZE) begin
                r_n <= mfps_pkg::N_W'(mfps_pkg::MAX_SIZE);
            end else begin
                r_n <= mfps_pkg::N_W'(i_cfg_data);
            end
            r_col <= '0;
            r_row <= '0;
            r_min <= mfps_pkg::COST_MAX;
        end else if (in_acc) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + mfps_pkg::IDX_W'(1);
            end else begin
                r_col <= r_col + mfps_pkg::IDX_W'(1);
            end
            r_min <= is_last ? mfps_pkg::COST_MAX : new_min;
        end
    end

    // Read-pending flag for the right neighbor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= in_acc && !last_col;
        end
    end

    // Neighbor window: slide within a row, reload from the first two columns at a row end.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_left <= r_above;
            if (last_col) begin
                r_above <= (r_col == '0) ? cost : r_col0;
                r_right <= (r_col == mfps_pkg::IDX_W'(1)) ? cost : r_col1;
            end else begin
                r_above <= right_cur;
            end
            if (r_col == '0) begin
                r_col0 <= cost;
            end
            if (r_col == mfps_pkg::IDX_W'(1)) begin
                r_col1 <= cost;
            end
        end else if (r_pend) begin
            r_right <= rd_data;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && is_last) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && is_last) begin
            r_out <= mfps_pkg::OUT_W'(new_min);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    // Indices stay inside the configured matrix.
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mfps_pkg::N_W'(r_col) < r_n)
        else $error("column index outside the matrix");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mfps_pkg::N_W'(r_row) < r_n)
        else $error("row index outside the matrix");

    // The last entry of a matrix always loads the output register.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && is_last |=> o_m_axis_tvalid)
        else $error("result not presented after last entry");

    // A pending read follows an accepted entry of the same row.
    a_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !last_col && !i_cfg_we |=> r_pend && (r_col != '0))
        else $error("right neighbor fetch lost");

endmodule

### dv/min_falling_path_sum_test.sv
// Self-checking testbench for the streaming minimum falling path sum block.
`timescale 1ns / 1ps

module min_falling_path_sum_test;

    typedef logic [mfps_pkg::ENTRY_W-1:0] t_entry;
    typedef logic [mfps_pkg::OUT_W-1:0]   t_sum;
    typedef logic [mfps_pkg::CFG_W-1:0]   t_cfg;

    // One directed request: optional size write ahead of it, and a result
    // value typed in where it is obvious.
    typedef struct packed {
        logic   wr;
        t_cfg   size;
        t_entry value;
        logic   pinned;
        t_sum   sum;
    } t_row;

    // Receiver ready patterns.
    typedef enum logic [1:0] {RX_OPEN, RX_STEADY, RX_COIN, RX_SPARSE} t_rx_mode;

    localparam int  DIR_ROWS     = 25;
    localparam int  RANDOM_ITEMS = 900;
    localparam int  LONG_HOLD    = 400;
    localparam int  SETTLE       = 8;
    localparam int  LIMIT        = 2000000;

    logic   i_clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   cfg_we = 1'b0;
    t_cfg   cfg_data = '0;
    logic   s_valid = 1'b0;
    t_entry s_data = '0;
    logic   m_ready = 1'b0;
    logic   o_s_axis_tready;
    logic   o_m_axis_tvalid;
    t_sum   o_m_axis_tdata;

    // Path cost model of the block.
    mfps_pkg::t_cost  cost_row [mfps_pkg::MAX_SIZE];
    mfps_pkg::t_cost  left_old = '0;
    mfps_pkg::t_cost  run_min = mfps_pkg::COST_MAX;
    int     row_at = 0;
    int     col_at = 0;
    t_cfg   size_reg = 8'd1;

    t_sum   expected_sums [$];
    t_row   dir_rows [DIR_ROWS];

    int     errors = 0;
    int     cycles = 0;
    int     entries_sent = 0;
    int     matrices_done = 0;
    int     size_writes = 0;
    int     results_checked = 0;
    int     burst_left = 1;
    bit     valid_up = 1'b0;

    // Receiver state.
    logic     hold_go = 1'b0;
    logic     hold_done = 1'b0;
    int       hold_left = 0;
    int       seg_left = 0;
    int       rx_tick = 0;
    t_rx_mode seg_mode = RX_OPEN;

    min_falling_path_sum i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),        // [7:0] matrix_size
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),          // [15:0] entry_value
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)   // [23:0] min_path_sum
    );

    always #5 i_clk = ~i_clk;

    // A size of zero works as one, and anything past the cost row as its full length.
    function automatic int eff_size(input t_cfg s);
        if (s == '0) return 1;
        if (int'(s) > mfps_pkg::MAX_SIZE) return mfps_pkg::MAX_SIZE;
        return int'(s);
    endfunction

    function automatic void restart_path();
        left_old = '0;
        row_at = 0;
        col_at = 0;
        run_min = mfps_pkg::COST_MAX;
    endfunction

    // Folds one entry into the cost row; returns 1 when the matrix completes.
    function automatic bit fold_entry(input t_entry raw, output t_sum sum);
        int n;
        int c;
        int r;
        int v;
        int best;
        int cost;
        int above;
        n = eff_size(size_reg);
        c = col_at;
        r = row_at;
        v = int'($signed(raw));
        sum = '0;
        if (c >= n || r >= n) begin
            restart_path();
            c = 0;
            r = 0;
        end
        if (r == 0) begin
            cost = v;
        end else begin
            above = int'(cost_row[c]);
            best = above;
            if (c > 0 && int'(left_old) < best) best = int'(left_old);
            if (c + 1 < n && int'(cost_row[c + 1]) < best) best = int'(cost_row[c + 1]);
            cost = v + best;
            if (cost > int'(mfps_pkg::COST_MAX)) cost = int'(mfps_pkg::COST_MAX);
            if (cost < int'(mfps_pkg::COST_MIN)) cost = int'(mfps_pkg::COST_MIN);
            left_old = mfps_pkg::t_cost'(above);
        end
        cost_row[c] = mfps_pkg::t_cost'(cost);
        if (r + 1 == n && cost < int'(run_min)) run_min = mfps_pkg::t_cost'(cost);
        if (c + 1 < n) begin
            col_at = c + 1;
            return 1'b0;
        end
        col_at = 0;
        if (r + 1 < n) begin
            row_at = r + 1;
            return 1'b0;
        end
        sum = {run_min[mfps_pkg::COST_W-1], run_min};
        restart_path();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input t_sum got, input t_sum want);
        $display("mismatch at cycle %0d: %s, got %0d, expected %0d",
                 cycles, what, $signed(got), $signed(want));
        errors++;
    endtask

    // Drop the request line if it is up; used before idle waits.
    task automatic stop_stream();
        if (valid_up) begin
            s_valid <= 1'b0;
            valid_up = 1'b0;
        end
    endtask

    // Offer one entry, wait for it to be taken, then predict its result.
    task automatic send_entry(input t_entry value, input bit pinned, input t_sum pinned_sum);
        t_sum sum;
        bit   done;
        int   gap;
        s_data <= value;
        if (!valid_up) begin
            s_valid <= 1'b1;
            valid_up = 1'b1;
        end
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        done = fold_entry(value, sum);
        entries_sent++;
        if (done) matrices_done++;
        if (pinned) expected_sums.push_back(pinned_sum);
        else if (done) expected_sums.push_back(sum);
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            if (gap > 0) begin
                s_valid <= 1'b0;
                valid_up = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Size writes happen only with nothing in flight.
    task automatic write_size(input t_cfg value);
        stop_stream();
        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        size_reg = value;
        restart_path();
        size_writes++;
    endtask

    function automatic t_entry rand_entry();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3:    return t_entry'($urandom_range(0, 64) - 32);
            default: return t_entry'($urandom);
        endcase
    endfunction

    // Mostly small matrices, now and then a size of zero or a larger one.
    function automatic t_cfg pick_size();
        case ($urandom_range(0, 19))
            0:                 return 8'd0;
            1:                 return 8'd1;
            15, 16, 17:        return t_cfg'($urandom_range(7, 12));
            18:                return 8'd16;
            19:                return t_cfg'($urandom_range(17, 22));
            default:           return t_cfg'($urandom_range(2, 6));
        endcase
    endfunction

    // Cycle count and watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_sums.size());
            $display("min_falling_path_sum_test: FAIL");
            $finish;
        end
    end

    // Receiver: changing ready patterns, plus one long hold-off on request.
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            m_ready   <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_mode <= t_rx_mode'($urandom_range(0, 3));
                seg_left <= $urandom_range(20, 200);
            end else begin
                seg_left <= seg_left - 1;
            end
            case (seg_mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_STEADY: m_ready <= (rx_tick % 4 != 3);
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= ($urandom_range(0, 4) == 0);
                default:   m_ready <= 1'b1;
            endcase
        end
    end

    // Result checker: each taken result against the oldest expectation.
    always @(posedge i_clk) begin
        if (rst_n && o_m_axis_tvalid && m_ready) begin
            if (expected_sums.size() == 0) begin
                report_mismatch("result with none expected", o_m_axis_tdata, '0);
            end else begin
                if (o_m_axis_tdata !== expected_sums[0])
                    report_mismatch("min_path_sum", o_m_axis_tdata, expected_sums[0]);
                void'(expected_sums.pop_front());
                results_checked++;
            end
        end
    end

    // Stimulus: directed table, a pressure phase, random phases, then a
    // run at the largest size that is cut short.
    initial begin
        int   i;
        int   n;
        int   mats;
        int   random_items;
        t_cfg size;
        random_items = 0;
        dir_rows = '{
            // Reset size of one: each entry is its own result.
            '{1'b0, 8'd0,   16'h8000, 1'b1, 24'hFF8000},
            '{1'b0, 8'd0,   16'h7FFF, 1'b1, 24'h007FFF},
            '{1'b0, 8'd0,   16'h0000, 1'b1, 24'h000000},
            // A size of zero works as one.
            '{1'b1, 8'd0,   16'h0005, 1'b1, 24'h000005},
            // Two by two; the above and left neighbors win.
            '{1'b1, 8'd2,   16'h0001, 1'b0, 24'h000000},
            '{1'b0, 8'd0,   16'h0002, 1'b0, 24'h000000},
            '{1'b0, 8'd0,   16'h0003, 1'b0, 24'h000000},
            '{1'b0, 8'd0,   16'h0004, 1'b0, 24'h000000},
            // Two by two at the negative extreme.
            '{1'b1, 8'd2,   16'h8000, 1'b0, 24'h000000},
            '{1'b0, 8'd0,   16'h8000, 1'b0, 24'h000000},
            '{1'b0, 8'd0,   16'h8000, 1'b0, 24'h000000},
            '{1'b0, 8'd0,   16'h8000, 1'b1, 24'hFF0000},
            // Three by three, mixed values.
            '{1'b1, 8'd3,   16'h7FFF, 1'b0, 24'h000000},
            '{1'b0, 8'd0,   16'h8000, 1'b0, 24'h000000},
            '{1'b0, 8'd0,   16'h0010, 1'b0, 24'h000000},
            '{1'b0, 8'd0,   16'hFFFF, 1'b0, 24'h000000},
            '{1'b0, 8'd0,   16'h1234, 1'b0, 24'h000000},
            '{1'b0, 8'd0,   16'h8001, 1'b0, 24'h000000},
            '{1'b0, 8'd0,   16'h7FFE, 1'b0, 24'h000000},
            '{1'b0, 8'd0,   16'h0000, 1'b0, 24'h000000},
            '{1'b0, 8'd0,   16'h0F0F, 1'b0, 24'h000000},
            // Matrix cut short by a size write.
            '{1'b1, 8'd3,   16'h0100, 1'b0, 24'h000000},
            '{1'b0, 8'd0,   16'h0200, 1'b0, 24'h000000},
            '{1'b0, 8'd0,   16'h0300, 1'b0, 24'h000000},
            '{1'b1, 8'd1,   16'hFFFF, 1'b1, 24'hFFFFFF}
        };

        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        restart_path();
        @(posedge i_clk);

        for (i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].wr) write_size(dir_rows[i].size);
            send_entry(dir_rows[i].value, dir_rows[i].pinned, dir_rows[i].sum);
        end

        // The receiver holds off while small matrices keep coming.
        write_size(8'd2);
        hold_go <= 1'b1;
        repeat (30 * 4) send_entry(rand_entry(), 1'b0, '0);

        while (random_items < RANDOM_ITEMS) begin
            size = pick_size();
            write_size(size);
            n = eff_size(size);
            mats = $urandom_range(1, 5);
            repeat (mats * n * n) begin
                if (random_items < RANDOM_ITEMS) begin
                    send_entry(rand_entry(), 1'b0, '0);
                    random_items++;
                end
            end
            // Sometimes leave a matrix unfinished before the next size write.
            if (n > 1 && $urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, n * n - 1)) begin
                    if (random_items < RANDOM_ITEMS) begin
                        send_entry(rand_entry(), 1'b0, '0);
                        random_items++;
                    end
                end
            end
        end

        // Oversized write: two full rows of the whole cost row, then cut short.
        write_size(8'hFF);
        repeat (2 * mfps_pkg::MAX_SIZE + 3) send_entry(16'h8000, 1'b0, '0);
        write_size(8'd1);
        send_entry(16'h7FFF, 1'b1, 24'h007FFF);

        stop_stream();
        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE * 4) @(posedge i_clk);

        $display("run covered %0d entries in %0d matrices over %0d size writes,",
                 entries_sent, matrices_done, size_writes);
        $display("with %0d results checked and %0d mismatches in %0d cycles",
                 results_checked, errors, cycles);
        if (errors == 0) begin
            $display("min_falling_path_sum_test: PASS");
        end else begin
            $display("min_falling_path_sum_test: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
hdl/mfps_pkg.sv
hdl/mfps_ram.sv
hdl/min_falling_path_sum.sv
dv/min_falling_path_sum_test.sv
